// ===== sv/tksi_pkg.sv =====
`default_nettype none

package tksi_pkg;

    // Field widths of the stream words.
    localparam int SCORE_W     = 32;
    localparam int LINE_W      = 20;
    localparam int SLOT_W      = 4;
    localparam int POS_W       = 5;
    localparam int ENTRIES_DEF = 16;

    // Item kinds carried on s_tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Candidate broadcast to every cell.
    typedef struct packed {
        logic               en;
        logic [SCORE_W-1:0] score;
        logic [LINE_W-1:0]  line;
    } ins_t;

    // What one cell hands to the next one down the chain.
    typedef struct packed {
        logic               beat;
        logic [SCORE_W-1:0] score;
        logic [LINE_W-1:0]  line;
    } cell_link_t;

endpackage

`default_nettype wire

// ===== sv/tksi_cell.sv =====
`default_nettype none

module tksi_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  tksi_pkg::ins_t       ins,
    input  tksi_pkg::cell_link_t link_in,
    output tksi_pkg::cell_link_t link_out
);

    logic [tksi_pkg::SCORE_W-1:0] score_reg;
    logic [tksi_pkg::SCORE_W-1:0] score_next;
    logic [tksi_pkg::LINE_W-1:0]  line_reg;
    logic [tksi_pkg::LINE_W-1:0]  line_next;
    logic                         beat;

    // The candidate wins over this slot on a higher score, or on an equal
    // nonzero score with a lower line number. An empty slot loses to any
    // nonzero score.
    always_comb begin
        beat = (ins.score > score_reg) ||
               ((ins.score == score_reg) && (score_reg != '0) && (ins.line < line_reg));
    end

    // If the slot above was beaten, its entry moves down into this one;
    // otherwise the first beaten slot takes the candidate.
    always_comb begin
        score_next = score_reg;
        line_next  = line_reg;
        if (ins.en) begin
            if (link_in.beat) begin
                score_next = link_in.score;
                line_next  = link_in.line;
            end else if (beat) begin
                score_next = ins.score;
                line_next  = ins.line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg <= '0;
            line_reg  <= '0;
        end else begin
            score_reg <= score_next;
            line_reg  <= line_next;
        end
    end

    assign link_out.beat  = beat;
    assign link_out.score = score_reg;
    assign link_out.line  = line_reg;

endmodule

`default_nettype wire

// ===== sv/top_k_sorted_insert.sv =====
// Sorted list of the best ENTRIES (score, line) pairs, best score first and
// equal scores in ascending line order.
// Input channel (s_): one word per item. s_tuser selects an insert or a read.
// An insert places a nonzero score at the first slot it beats and pushes the
// rest down by one; the last entry falls off. A read returns one slot.
// Result channel (m_): exactly one word per input word, in order.
// m_tvalid rises in the cycle after acceptance. One item is taken every
// cycle while results are taken; the figure is set by the row of cells, which
// all compare against the candidate and shift in the same cycle.
// A single output register holds the result; while m_tready is low and a
// result is waiting, s_tready is low and the list is left untouched.
// Reset (aresetn low at a clock edge) empties every slot at once and drops
// any waiting result; there is no clearing pass afterwards.
// Only slots 0 to 15 can be read; a read beyond the list returns zeros.
`default_nettype none

module top_k_sorted_insert #(
    parameter int ENTRIES = tksi_pkg::ENTRIES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // new_score [31:0], new_line [51:32], read_slot [55:52]
    input  wire  [55:0] s_tdata,
    // kind [0]
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // placed [0], position [5:1], slot_score [37:6], slot_line [57:38],
    // slot_filled [58], zero fill [63:59]
    output logic [63:0] m_tdata
);

    localparam int PW   = $clog2(ENTRIES + 1);
    localparam int RD_N = (ENTRIES < 16) ? ENTRIES : 16;

    logic                          accept;
    logic                          kind;
    logic [tksi_pkg::SCORE_W-1:0]  new_score;
    logic [tksi_pkg::LINE_W-1:0]   new_line;
    logic [tksi_pkg::SLOT_W-1:0]   read_slot;

    tksi_pkg::ins_t                ins;
    tksi_pkg::cell_link_t          links [ENTRIES+1];
    logic [ENTRIES-1:0]            beat_vec;
    logic [ENTRIES-1:0]            above_vec;
    logic [ENTRIES-1:0]            landing;

    logic                          placed;
    logic [PW-1:0]                 pos_wide;
    logic [PW+4:0]                 pos_ext;
    logic [tksi_pkg::POS_W-1:0]    position;
    logic [tksi_pkg::SCORE_W-1:0]  rd_score;
    logic [tksi_pkg::LINE_W-1:0]   rd_line;
    logic [tksi_pkg::SCORE_W-1:0]  slot_score;
    logic [tksi_pkg::LINE_W-1:0]   slot_line;
    logic                          slot_filled;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [63:0]                   out_data_reg;
    logic [63:0]                   out_data_next;

    // Input word unpacking and handshake.
    assign kind      = s_tuser[0];
    assign new_score = s_tdata[31:0];
    assign new_line  = s_tdata[51:32];
    assign read_slot = s_tdata[55:52];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Candidate broadcast; a zero score never enters the list.
    assign ins.en    = accept && (kind == tksi_pkg::KIND_INSERT) && (new_score != '0);
    assign ins.score = new_score;
    assign ins.line  = new_line;

    // Row of cells; slot 0 sees an empty neighbor above it.
    assign links[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tksi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ins      (ins),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
        assign beat_vec[g]  = links[g+1].beat;
        assign above_vec[g] = links[g].beat;
    end

    // The landing slot is the first beaten one; the list is sorted, so the
    // beaten slots form one run down to the end. Only an insert that is
    // actually taken can land; reads and dropped inserts report no slot.
    assign landing = ins.en ? (beat_vec & ~above_vec) : '0;
    assign placed  = |landing;

    always_comb begin
        pos_wide = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (landing[i]) begin
                pos_wide = pos_wide | PW'(i);
            end
        end
        if (!placed) begin
            pos_wide = PW'(ENTRIES);
        end
    end

    assign pos_ext  = (PW + 5)'(pos_wide);
    assign position = pos_ext[tksi_pkg::POS_W-1:0];

    // Read select over the slots that a 4-bit index can reach.
    always_comb begin
        rd_score = '0;
        rd_line  = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (read_slot == tksi_pkg::SLOT_W'(i)) begin
                rd_score = links[i+1].score;
                rd_line  = links[i+1].line;
            end
        end
    end

    // Result word for the accepted item.
    always_comb begin
        slot_score  = '0;
        slot_line   = '0;
        slot_filled = 1'b0;
        if (kind == tksi_pkg::KIND_READ) begin
            slot_score  = rd_score;
            slot_line   = rd_line;
            slot_filled = (rd_score != '0);
        end
        out_data_next = {5'b0, slot_filled, slot_line, slot_score, position, placed};
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // At most one slot takes the candidate.
    a_landing_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(landing))
        else $error("more than one landing slot");

    // The list stays sorted, so a beaten slot is followed only by beaten slots.
    a_beat_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (above_vec & ~beat_vec) == '0)
        else $error("beaten slots do not form one run");

    // A result never reports both a placement and a filled read slot.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[58]))
        else $error("result mixes insert and read fields");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
